FILE: hw/rtl/ppg_seq_pkg.sv
package ppg_seq_pkg;

   localparam int RING_DEPTH   = 512;
   localparam int PORTION_SIZE = 100;

   localparam int INDEX_W  = $clog2(RING_DEPTH);
   localparam int COUNT_W  = 10;
   localparam int SAMPLE_W = 18;
   localparam int WORD_W   = 24;
   localparam int DRIVE_W  = 8;
   localparam int LEVEL_W  = 18;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 18;

   localparam int PORTION_MOD = PORTION_SIZE % RING_DEPTH;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   localparam logic [WORD_W-1:0] MASK_15B = 24'h007FFF;
   localparam logic [WORD_W-1:0] MASK_16B = 24'h00FFFF;
   localparam logic [WORD_W-1:0] MASK_17B = 24'h01FFFF;
   localparam logic [WORD_W-1:0] MASK_18B = 24'h03FFFF;

   localparam logic MODE_SAMPLE = 1'b0;
   localparam logic MODE_TICK   = 1'b1;

   typedef enum logic [1:0] {
      PW_SHIFT3 = 2'd0,
      PW_SHIFT2 = 2'd1,
      PW_SHIFT1 = 2'd2,
      PW_SHIFT0 = 2'd3
   } pulse_width_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PULSE_WIDTH  = 3'd0,
      CSR_PRESENCE_ON  = 3'd1,
      CSR_PRESENCE_OFF = 3'd2,
      CSR_RED_HIGH     = 3'd3,
      CSR_IR_HIGH      = 3'd4,
      CSR_RED_LOW      = 3'd5,
      CSR_IR_LOW       = 3'd6,
      CSR_UNUSED       = 3'd7
   } csr_index_type;

   typedef enum logic [3:0] {
      PH_IDLE    = 4'b0001,
      PH_FILL    = 4'b0010,
      PH_COMPUTE = 4'b0100,
      PH_COLLECT = 4'b1000
   } phase_type;

   localparam logic [1:0] PHASE_CODE_IDLE    = 2'd0;
   localparam logic [1:0] PHASE_CODE_FILL    = 2'd1;
   localparam logic [1:0] PHASE_CODE_COMPUTE = 2'd2;
   localparam logic [1:0] PHASE_CODE_COLLECT = 2'd3;

   function automatic logic [1:0] phase_code(input phase_type ph);
      logic [1:0] code;
      unique case (ph)
         PH_IDLE:    code = PHASE_CODE_IDLE;
         PH_FILL:    code = PHASE_CODE_FILL;
         PH_COMPUTE: code = PHASE_CODE_COMPUTE;
         PH_COLLECT: code = PHASE_CODE_COLLECT;
         default:    code = PHASE_CODE_IDLE;
      endcase
      return code;
   endfunction

   function automatic logic [SAMPLE_W-1:0] scale_red(input pulse_width_type pw,
                                                     input logic [WORD_W-1:0] raw);
      logic [WORD_W-1:0] v;
      unique case (pw)
         PW_SHIFT3: v = (raw >> 3) & MASK_15B;
         PW_SHIFT2: v = (raw >> 2) & MASK_16B;
         PW_SHIFT1: v = (raw >> 1) & MASK_17B;
         PW_SHIFT0: v = raw & MASK_18B;
         default:   v = raw & MASK_18B;
      endcase
      return v[SAMPLE_W-1:0];
   endfunction

endpackage

FILE: hw/rtl/ppg_sample_acquisition_sequencer_top.sv
// Optical pulse sensor acquisition sequencer. Each req_ transaction is either a sample
// (req_mode 0: red word scaled by the pulse-width code, infrared cut to 18 bits, reported
// with its ring slot, presence hysteresis updated, ring head and saturating count advanced)
// or a tick (req_mode 1: one step of the idle/fill/compute/collect sequencer, which reports
// LED drive updates and analysis-window requests). Every transaction gives exactly one rsp_
// transaction; the block takes one transaction per cycle while rsp_stall is low, through a
// single input register and a single result register with the sequencer state updated between
// them. Registers are written on the csr_ port, which is always ready; index 7 is ignored.
// Write registers only while no transaction is in flight.
module ppg_sample_acquisition_sequencer_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_mode,
   input  logic [ppg_seq_pkg::WORD_W-1:0]       req_red_word,
   input  logic [ppg_seq_pkg::WORD_W-1:0]       req_ir_word,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_sample_valid,
   output logic [ppg_seq_pkg::SAMPLE_W-1:0]     rsp_red_sample,
   output logic [ppg_seq_pkg::SAMPLE_W-1:0]     rsp_ir_sample,
   output logic [ppg_seq_pkg::INDEX_W-1:0]      rsp_write_index,
   output logic                                 rsp_presence,
   output logic [1:0]                           rsp_phase,
   output logic                                 rsp_drive_update,
   output logic [ppg_seq_pkg::DRIVE_W-1:0]      rsp_red_drive,
   output logic [ppg_seq_pkg::DRIVE_W-1:0]      rsp_ir_drive,
   output logic                                 rsp_window_request,
   output logic [ppg_seq_pkg::INDEX_W-1:0]      rsp_window_start,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ppg_seq_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ppg_seq_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import ppg_seq_pkg::*;

   pulse_width_type       pulse_width_ff;
   logic [LEVEL_W-1:0]    on_level_ff;
   logic [LEVEL_W-1:0]    off_level_ff;
   logic [DRIVE_W-1:0]    red_high_ff;
   logic [DRIVE_W-1:0]    ir_high_ff;
   logic [DRIVE_W-1:0]    red_low_ff;
   logic [DRIVE_W-1:0]    ir_low_ff;

   logic                  in_valid_ff;
   logic                  in_mode_ff;
   logic [WORD_W-1:0]     in_red_ff;
   logic [WORD_W-1:0]     in_ir_ff;

   phase_type             phase_ff, phase_in;
   logic                  presence_ff, presence_in;
   logic [INDEX_W-1:0]    head_ff, head_in;
   logic [INDEX_W-1:0]    tail_ff, tail_in;
   logic [COUNT_W-1:0]    count_ff, count_in;

   logic                  out_valid_ff;
   logic                  out_sample_valid_ff;
   logic [SAMPLE_W-1:0]   out_red_ff;
   logic [SAMPLE_W-1:0]   out_ir_ff;
   logic [INDEX_W-1:0]    out_widx_ff;
   logic                  out_presence_ff;
   logic [1:0]            out_phase_ff;
   logic                  out_update_ff;
   logic [DRIVE_W-1:0]    out_red_drive_ff;
   logic [DRIVE_W-1:0]    out_ir_drive_ff;
   logic                  out_wreq_ff;
   logic [INDEX_W-1:0]    out_wstart_ff;

   logic                  out_take;
   logic                  advance;
   logic                  in_take;

   logic [SAMPLE_W-1:0]   red_s;
   logic [SAMPLE_W-1:0]   ir_s;
   logic                  upd;
   logic [DRIVE_W-1:0]    rdrv;
   logic [DRIVE_W-1:0]    idrv;
   logic                  wreq;
   logic [INDEX_W:0]      tail_sum;
   logic [INDEX_W-1:0]    tail_step;
   logic [INDEX_W-1:0]    head_step;
   logic [COUNT_W:0]      fill_sum;

   assign out_take  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_take;
   assign req_stall = in_valid_ff && !out_take;
   assign in_take   = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_width_ff <= PW_SHIFT2;
         on_level_ff    <= LEVEL_W'(50000);
         off_level_ff   <= LEVEL_W'(30000);
         red_high_ff    <= DRIVE_W'(36);
         ir_high_ff     <= DRIVE_W'(36);
         red_low_ff     <= DRIVE_W'(0);
         ir_low_ff      <= DRIVE_W'(2);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_PULSE_WIDTH:  pulse_width_ff <= pulse_width_type'(csr_wdata[1:0]);
            CSR_PRESENCE_ON:  on_level_ff    <= csr_wdata[LEVEL_W-1:0];
            CSR_PRESENCE_OFF: off_level_ff   <= csr_wdata[LEVEL_W-1:0];
            CSR_RED_HIGH:     red_high_ff    <= csr_wdata[DRIVE_W-1:0];
            CSR_IR_HIGH:      ir_high_ff     <= csr_wdata[DRIVE_W-1:0];
            CSR_RED_LOW:      red_low_ff     <= csr_wdata[DRIVE_W-1:0];
            CSR_IR_LOW:       ir_low_ff      <= csr_wdata[DRIVE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         in_mode_ff <= req_mode;
         in_red_ff  <= req_red_word;
         in_ir_ff   <= req_ir_word;
      end
   end

   assign head_step = (head_ff == INDEX_W'(RING_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign tail_sum  = {1'b0, tail_ff} + (INDEX_W + 1)'(PORTION_MOD);
   assign tail_step = (tail_sum >= (INDEX_W + 1)'(RING_DEPTH))
                      ? INDEX_W'(tail_sum - (INDEX_W + 1)'(RING_DEPTH))
                      : tail_sum[INDEX_W-1:0];
   assign fill_sum  = {1'b0, count_ff} + (COUNT_W + 1)'(PORTION_SIZE);

   always_comb begin
      phase_in    = phase_ff;
      presence_in = presence_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      red_s       = '0;
      ir_s        = '0;
      upd         = 1'b0;
      rdrv        = '0;
      idrv        = '0;
      wreq        = 1'b0;
      if (in_mode_ff == MODE_SAMPLE) begin
         red_s = scale_red(pulse_width_ff, in_red_ff);
         ir_s  = in_ir_ff[SAMPLE_W-1:0];
         if (presence_ff) begin
            if (ir_s < off_level_ff) presence_in = 1'b0;
         end else begin
            if (ir_s > on_level_ff) presence_in = 1'b1;
         end
         head_in = head_step;
         if (count_ff != COUNT_MAX) count_in = count_ff + 1'b1;
      end else begin
         priority if (phase_ff == PH_IDLE) begin
            if (presence_ff) begin
               count_in = '0;
               tail_in  = head_ff;
               upd      = 1'b1;
               rdrv     = red_high_ff;
               idrv     = ir_high_ff;
               phase_in = PH_FILL;
            end
         end else if (!presence_ff) begin
            upd      = 1'b1;
            rdrv     = red_low_ff;
            idrv     = ir_low_ff;
            phase_in = PH_IDLE;
         end else if (phase_ff == PH_FILL) begin
            if (fill_sum > (COUNT_W + 1)'(RING_DEPTH)) phase_in = PH_COMPUTE;
         end else if (phase_ff == PH_COMPUTE) begin
            wreq     = 1'b1;
            tail_in  = tail_step;
            count_in = '0;
            phase_in = PH_COLLECT;
         end else begin
            if (count_ff > COUNT_W'(PORTION_SIZE)) phase_in = PH_COMPUTE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         presence_ff <= 1'b0;
         head_ff     <= '0;
         tail_ff     <= '0;
         count_ff    <= '0;
      end else if (advance) begin
         phase_ff    <= phase_in;
         presence_ff <= presence_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_take) begin
         out_valid_ff <= advance;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_sample_valid_ff <= (in_mode_ff == MODE_SAMPLE);
         out_red_ff          <= red_s;
         out_ir_ff           <= ir_s;
         out_widx_ff         <= head_ff;
         out_presence_ff     <= presence_in;
         out_phase_ff        <= phase_code(phase_in);
         out_update_ff       <= upd;
         out_red_drive_ff    <= rdrv;
         out_ir_drive_ff     <= idrv;
         out_wreq_ff         <= wreq;
         out_wstart_ff       <= wreq ? tail_ff : tail_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_sample_valid   = out_sample_valid_ff;
   assign rsp_red_sample     = out_red_ff;
   assign rsp_ir_sample      = out_ir_ff;
   assign rsp_write_index    = out_widx_ff;
   assign rsp_presence       = out_presence_ff;
   assign rsp_phase          = out_phase_ff;
   assign rsp_drive_update   = out_update_ff;
   assign rsp_red_drive      = out_red_drive_ff;
   assign rsp_ir_drive       = out_ir_drive_ff;
   assign rsp_window_request = out_wreq_ff;
   assign rsp_window_start   = out_wstart_ff;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending after reset");

   a_wreq_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_window_request |-> rsp_phase == PHASE_CODE_COLLECT && rsp_presence)
      else $error("window request outside collect entry");

   a_update_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_drive_update |->
         (rsp_phase == PHASE_CODE_FILL && rsp_presence) ||
         (rsp_phase == PHASE_CODE_IDLE && !rsp_presence))
      else $error("drive update with inconsistent phase");

   a_sample_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sample_valid |-> !rsp_drive_update && !rsp_window_request)
      else $error("sample result carries sequencer action");

endmodule

FILE: sim/ppg_sample_acquisition_sequencer_top_tb.sv
module ppg_sample_acquisition_sequencer_top_tb;
   import ppg_seq_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

   typedef struct {
      logic                sample_valid;
      logic [SAMPLE_W-1:0] red_sample;
      logic [SAMPLE_W-1:0] ir_sample;
      logic [INDEX_W-1:0]  write_index;
      logic                presence;
      logic [1:0]          phase;
      logic                drive_update;
      logic [DRIVE_W-1:0]  red_drive;
      logic [DRIVE_W-1:0]  ir_drive;
      logic                window_request;
      logic [INDEX_W-1:0]  window_start;
   } acq_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_mode = MODE_SAMPLE;
   logic [WORD_W-1:0]     req_red_word = '0;
   logic [WORD_W-1:0]     req_ir_word = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_sample_valid;
   logic [SAMPLE_W-1:0]   rsp_red_sample;
   logic [SAMPLE_W-1:0]   rsp_ir_sample;
   logic [INDEX_W-1:0]    rsp_write_index;
   logic                  rsp_presence;
   logic [1:0]            rsp_phase;
   logic                  rsp_drive_update;
   logic [DRIVE_W-1:0]    rsp_red_drive;
   logic [DRIVE_W-1:0]    rsp_ir_drive;
   logic                  rsp_window_request;
   logic [INDEX_W-1:0]    rsp_window_start;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_PULSE_WIDTH;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // configuration as the block should hold it
   pulse_width_type    cfg_pulse_width = PW_SHIFT2;
   logic [LEVEL_W-1:0] cfg_on_level = 50000;
   logic [LEVEL_W-1:0] cfg_off_level = 30000;
   logic [DRIVE_W-1:0] cfg_red_high = 36;
   logic [DRIVE_W-1:0] cfg_ir_high = 36;
   logic [DRIVE_W-1:0] cfg_red_low = 0;
   logic [DRIVE_W-1:0] cfg_ir_low = 2;

   // sequencer state as the block should hold it
   logic [1:0]         acq_phase = PHASE_CODE_IDLE;
   logic               acq_presence = 1'b0;
   logic [INDEX_W-1:0] acq_head = '0;
   logic [INDEX_W-1:0] acq_tail = '0;
   logic [COUNT_W-1:0] acq_count = '0;

   acq_result_type expected_results_q[$];

   int error_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 25;
   int rsp_stall_pct = 25;
   int holdoff_request = 0;
   int holdoff_left = 0;

   ppg_sample_acquisition_sequencer_top u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_red_word       (req_red_word),
      .req_ir_word        (req_ir_word),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_sample_valid   (rsp_sample_valid),
      .rsp_red_sample     (rsp_red_sample),
      .rsp_ir_sample      (rsp_ir_sample),
      .rsp_write_index    (rsp_write_index),
      .rsp_presence       (rsp_presence),
      .rsp_phase          (rsp_phase),
      .rsp_drive_update   (rsp_drive_update),
      .rsp_red_drive      (rsp_red_drive),
      .rsp_ir_drive       (rsp_ir_drive),
      .rsp_window_request (rsp_window_request),
      .rsp_window_start   (rsp_window_start),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic acq_result_type predict_acquisition(input logic mode,
                                                      input logic [WORD_W-1:0] red_word,
                                                      input logic [WORD_W-1:0] ir_word);
      acq_result_type    r;
      logic [WORD_W-1:0] red_scaled;
      logic              window_taken;
      r = '{default: '0};
      window_taken = 1'b0;
      if (mode == MODE_SAMPLE) begin
         case (cfg_pulse_width)
            PW_SHIFT3: red_scaled = (red_word >> 3) & MASK_15B;
            PW_SHIFT2: red_scaled = (red_word >> 2) & MASK_16B;
            PW_SHIFT1: red_scaled = (red_word >> 1) & MASK_17B;
            default:   red_scaled = red_word & MASK_18B;
         endcase
         r.sample_valid = 1'b1;
         r.red_sample = red_scaled[SAMPLE_W-1:0];
         r.ir_sample = ir_word[SAMPLE_W-1:0];
         r.write_index = acq_head;
         if (acq_presence) begin
            if (r.ir_sample < cfg_off_level) acq_presence = 1'b0;
         end else if (r.ir_sample > cfg_on_level) begin
            acq_presence = 1'b1;
         end
         acq_head = INDEX_W'((int'(acq_head) + 1) % RING_DEPTH);
         if (acq_count != COUNT_MAX) acq_count++;
      end else begin
         if (acq_phase == PHASE_CODE_IDLE) begin
            if (acq_presence) begin
               acq_count = '0;
               acq_tail = acq_head;
               r.drive_update = 1'b1;
               r.red_drive = cfg_red_high;
               r.ir_drive = cfg_ir_high;
               acq_phase = PHASE_CODE_FILL;
            end
         end else if (!acq_presence) begin
            r.drive_update = 1'b1;
            r.red_drive = cfg_red_low;
            r.ir_drive = cfg_ir_low;
            acq_phase = PHASE_CODE_IDLE;
         end else begin
            case (acq_phase)
               PHASE_CODE_FILL: begin
                  if (int'(acq_count) + PORTION_SIZE > RING_DEPTH)
                     acq_phase = PHASE_CODE_COMPUTE;
               end
               PHASE_CODE_COMPUTE: begin
                  r.window_request = 1'b1;
                  r.window_start = acq_tail;
                  window_taken = 1'b1;
                  acq_tail = INDEX_W'((int'(acq_tail) + PORTION_SIZE) % RING_DEPTH);
                  acq_count = '0;
                  acq_phase = PHASE_CODE_COLLECT;
               end
               default: begin
                  if (int'(acq_count) > PORTION_SIZE) acq_phase = PHASE_CODE_COMPUTE;
               end
            endcase
         end
         r.write_index = acq_head;
      end
      if (!window_taken) r.window_start = acq_tail;
      r.presence = acq_presence;
      r.phase = acq_phase;
      return r;
   endfunction

   function automatic void check_field(input string name, input int exp_val,
                                       input int act_val);
      if (exp_val != act_val) begin
         $error("%s expected %0d actual %0d", name, exp_val, act_val);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      acq_result_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results_q.size() == 0) begin
            $error("result transaction with no request pending");
            error_count++;
         end else begin
            exp_r = expected_results_q.pop_front();
            check_field("sample_valid", int'(exp_r.sample_valid), int'(rsp_sample_valid));
            check_field("red_sample", int'(exp_r.red_sample), int'(rsp_red_sample));
            check_field("ir_sample", int'(exp_r.ir_sample), int'(rsp_ir_sample));
            check_field("write_index", int'(exp_r.write_index), int'(rsp_write_index));
            check_field("presence", int'(exp_r.presence), int'(rsp_presence));
            check_field("phase", int'(exp_r.phase), int'(rsp_phase));
            check_field("drive_update", int'(exp_r.drive_update), int'(rsp_drive_update));
            check_field("red_drive", int'(exp_r.red_drive), int'(rsp_red_drive));
            check_field("ir_drive", int'(exp_r.ir_drive), int'(rsp_ir_drive));
            check_field("window_request", int'(exp_r.window_request),
                        int'(rsp_window_request));
            check_field("window_start", int'(exp_r.window_start), int'(rsp_window_start));
         end
      end
   end

   always @(posedge clock) begin
      if (holdoff_request != 0) begin
         holdoff_left = holdoff_request;
         holdoff_request = 0;
      end
      if (holdoff_left != 0) begin
         holdoff_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   function automatic logic [WORD_W-1:0] present_ir();
      logic [LEVEL_W-1:0] low;
      if (cfg_on_level == LEVEL_MAX) low = LEVEL_MAX;
      else low = LEVEL_W'($urandom_range(LEVEL_MAX, cfg_on_level + 1));
      return {6'($urandom), low};
   endfunction

   function automatic logic [WORD_W-1:0] band_ir();
      logic [LEVEL_W-1:0] low;
      if (cfg_on_level >= cfg_off_level)
         low = LEVEL_W'($urandom_range(cfg_on_level, cfg_off_level));
      else
         low = LEVEL_W'($urandom_range(cfg_off_level, cfg_on_level));
      return {6'($urandom), low};
   endfunction

   task automatic send_item(input logic mode, input logic [WORD_W-1:0] red_word,
                            input logic [WORD_W-1:0] ir_word);
      req_valid <= 1'b1;
      req_mode <= mode;
      req_red_word <= red_word;
      req_ir_word <= ir_word;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_results_q.push_back(predict_acquisition(mode, red_word, ir_word));
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   task automatic send_samples(input int n);
      repeat (n) send_item(MODE_SAMPLE, WORD_W'($urandom), present_ir());
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_results_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_PULSE_WIDTH:  cfg_pulse_width = pulse_width_type'(data[1:0]);
         CSR_PRESENCE_ON:  cfg_on_level = data[LEVEL_W-1:0];
         CSR_PRESENCE_OFF: cfg_off_level = data[LEVEL_W-1:0];
         CSR_RED_HIGH:     cfg_red_high = data[DRIVE_W-1:0];
         CSR_IR_HIGH:      cfg_ir_high = data[DRIVE_W-1:0];
         CSR_RED_LOW:      cfg_red_low = data[DRIVE_W-1:0];
         CSR_IR_LOW:       cfg_ir_low = data[DRIVE_W-1:0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] pulse_width,
                            input logic [CSR_DATA_W-1:0] on_level,
                            input logic [CSR_DATA_W-1:0] off_level,
                            input logic [CSR_DATA_W-1:0] red_high,
                            input logic [CSR_DATA_W-1:0] ir_high,
                            input logic [CSR_DATA_W-1:0] red_low,
                            input logic [CSR_DATA_W-1:0] ir_low);
      wait_drained();
      write_csr(CSR_PULSE_WIDTH, pulse_width);
      write_csr(CSR_PRESENCE_ON, on_level);
      write_csr(CSR_PRESENCE_OFF, off_level);
      write_csr(CSR_RED_HIGH, red_high);
      write_csr(CSR_IR_HIGH, ir_high);
      write_csr(CSR_RED_LOW, red_low);
      write_csr(CSR_IR_LOW, ir_low);
      // unused index must leave every register alone
      write_csr(CSR_UNUSED, CSR_DATA_W'($urandom));
      csr_valid <= 1'b0;
   endtask

   task automatic test_presence_hysteresis();
      send_item(MODE_TICK, '0, '0);
      send_item(MODE_SAMPLE, 24'hFFFFFF, 24'h000000);
      send_item(MODE_SAMPLE, 24'h000000, 24'hFFFFFF);
      send_item(MODE_SAMPLE, 24'h5A5A5A, 24'd50000);
      send_item(MODE_TICK, 24'hFFFFFF, 24'hFFFFFF);
      send_item(MODE_TICK, '0, '0);
      send_item(MODE_SAMPLE, 24'h123456, 24'd30000);
      send_item(MODE_SAMPLE, 24'h654321, 24'd29999);
      send_item(MODE_TICK, '0, '0);
      send_item(MODE_SAMPLE, 24'hA5A5A5, 24'd50000);
      send_item(MODE_SAMPLE, 24'hC3C3C3, 24'd50001);
   endtask

   task automatic test_pulse_width_codes();
      for (int pw = 0; pw < 4; pw++) begin
         configure({16'hFFFF, 2'(pw)}, 50000, 30000, 36, 36, 0, 2);
         send_item(MODE_SAMPLE, 24'hFFFFFF, 24'hFC0000);
         send_item(MODE_SAMPLE, 24'hA5A5A5, 24'h03FFFF);
      end
   endtask

   task automatic test_register_extremes();
      configure('1, '1, '1, '1, '1, '1, '1);
      send_item(MODE_TICK, '0, '0);
      send_item(MODE_SAMPLE, 24'hFFFFFF, 24'hFFFFFF);
      send_item(MODE_TICK, '0, '0);
      configure('0, '0, '0, '0, '0, '0, '0);
      send_item(MODE_TICK, '0, '0);
      send_item(MODE_SAMPLE, 24'h000000, 24'h000000);
      send_item(MODE_TICK, '0, '0);
   endtask

   task automatic test_fill_and_window_boundaries();
      configure(CSR_DATA_W'(PW_SHIFT1), 1000, 500, 200, 150, 7, 9);
      send_item(MODE_SAMPLE, WORD_W'($urandom), 24'h000000);
      send_item(MODE_TICK, '0, '0);
      send_samples(1);
      send_item(MODE_TICK, '0, '0);
      // one sample short of the fill threshold
      send_samples(RING_DEPTH - PORTION_SIZE);
      send_item(MODE_TICK, '0, '0);
      // run the sample count into saturation before leaving fill
      send_samples(int'(COUNT_MAX) + 2 - (RING_DEPTH - PORTION_SIZE));
      send_item(MODE_TICK, '0, '0);
      send_item(MODE_TICK, '0, '0);
      // exactly one portion collected, then one past it
      send_samples(PORTION_SIZE);
      send_item(MODE_TICK, '0, '0);
      send_samples(1);
      send_item(MODE_TICK, '0, '0);
      send_item(MODE_TICK, '0, '0);
   endtask

   task automatic random_traffic(input int n);
      int sent;
      int len;
      sent = 0;
      while (sent < n) begin
         if ($urandom_range(9) != 0) begin
            len = $urandom_range(300, 50);
            if (len > n - sent) len = n - sent;
            repeat (len) begin
               if ($urandom_range(11) == 0)
                  send_item(MODE_TICK, WORD_W'($urandom), WORD_W'($urandom));
               else if ($urandom_range(49) == 0)
                  send_item(MODE_SAMPLE, WORD_W'($urandom), band_ir());
               else
                  send_item(MODE_SAMPLE, WORD_W'($urandom), present_ir());
            end
         end else begin
            len = $urandom_range(20, 1);
            if (len > n - sent) len = n - sent;
            repeat (len)
               send_item(1'($urandom_range(1)), WORD_W'($urandom), WORD_W'($urandom));
         end
         sent += len;
      end
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      holdoff_request = 80;
      random_traffic(60);
      // hold the sender until everything in flight has come back
      wait_drained();
      send_idle_pct = 25;
      rsp_stall_pct = 25;
      random_traffic(20);
   endtask

   task automatic test_idle_phases();
      configure(CSR_DATA_W'($urandom_range(3)), 60000, 25000,
                CSR_DATA_W'($urandom_range(255)), CSR_DATA_W'($urandom_range(255)),
                CSR_DATA_W'($urandom_range(255)), CSR_DATA_W'($urandom_range(255)));
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      random_traffic(40);
      configure(CSR_DATA_W'(PW_SHIFT3), 0, 0, 0, 0, 0, 0);
      send_idle_pct = 67;
      rsp_stall_pct = 0;
      random_traffic(40);
      configure(CSR_DATA_W'(PW_SHIFT0), CSR_DATA_W'(LEVEL_MAX - 1), LEVEL_MAX,
                255, 255, 255, 255);
      send_idle_pct = 0;
      rsp_stall_pct = 67;
      random_traffic(40);
      configure(CSR_DATA_W'($urandom_range(3)), CSR_DATA_W'($urandom_range(120000, 40000)),
                CSR_DATA_W'($urandom_range(39999, 10000)),
                CSR_DATA_W'($urandom_range(255)), CSR_DATA_W'($urandom_range(255)),
                CSR_DATA_W'($urandom_range(255)), CSR_DATA_W'($urandom_range(255)));
      send_idle_pct = 25;
      rsp_stall_pct = 25;
      random_traffic(40);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_presence_hysteresis();
      test_pulse_width_codes();
      test_register_extremes();
      test_fill_and_window_boundaries();
      test_backpressure();
      test_idle_phases();
      wait_drained();
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
